>>> design/npq_pkg.sv
// npq_pkg: shared types, constants and the distance function
// for the nearest palette pixel quantizer
// no dependencies
package npq_pkg;

    localparam int PAL_ENTRIES = 4;
    localparam int COMP_W      = 8;
    localparam int SQ_W        = 2 * COMP_W;
    localparam int PIXERR_W    = 18;
    localparam int SUM_W       = 24;
    localparam int INDEX_W     = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 3 * COMP_W;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // mid queue between classifier and accumulator
    localparam int MID_DEPTH = 4;
    localparam int MID_PTR_W = $clog2(MID_DEPTH);
    localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);

    // result queue at the output
    localparam int OUT_DEPTH = 2;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PAL_COLOR0 = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PAL_COLOR1 = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PAL_COLOR2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PAL_COLOR3 = 2'd3;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } color_t;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic              tile_last;
    } pixel_t;

    typedef struct packed {
        logic [INDEX_W-1:0]  color_index;
        logic [PIXERR_W-1:0] pixel_error;
        logic [SUM_W-1:0]    tile_error;
        logic                tile_done;
    } result_t;

    // one classified pixel: distance to every palette entry
    typedef struct packed {
        logic [PAL_ENTRIES-1:0][PIXERR_W-1:0] lane_dist;
        logic                                 tile_last;
    } mid_word_t;

    function automatic logic [COMP_W-1:0] abs_diff(
        input logic [COMP_W-1:0] a,
        input logic [COMP_W-1:0] b
    );
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // squared euclidean distance in rgb space
    function automatic logic [PIXERR_W-1:0] sq_dist(
        input pixel_t px,
        input color_t c
    );
        logic [COMP_W-1:0] d_r;
        logic [COMP_W-1:0] d_g;
        logic [COMP_W-1:0] d_b;
        logic [SQ_W-1:0]   s_r;
        logic [SQ_W-1:0]   s_g;
        logic [SQ_W-1:0]   s_b;
        d_r = abs_diff(px.red, c.red);
        d_g = abs_diff(px.green, c.green);
        d_b = abs_diff(px.blue, c.blue);
        s_r = SQ_W'(d_r) * SQ_W'(d_r);
        s_g = SQ_W'(d_g) * SQ_W'(d_g);
        s_b = SQ_W'(d_b) * SQ_W'(d_b);
        return PIXERR_W'(s_r) + PIXERR_W'(s_g) + PIXERR_W'(s_b);
    endfunction

endpackage

>>> design/npq_front.sv
// npq_front: palette registers and the four distance lanes
// classifies each accepted pixel into a mid word
// depends on npq_pkg
module npq_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [npq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [npq_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  npq_pkg::pixel_t                pixel,
    output npq_pkg::mid_word_t             mid_word
);
    import npq_pkg::*;

    color_t pal_reg  [PAL_ENTRIES];
    color_t pal_next [PAL_ENTRIES];

    assign cfg_ready = 1'b1;

    always_comb
    begin
        for (int i = 0; i < PAL_ENTRIES; i++)
        begin
            pal_next[i] = pal_reg[i];
        end
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_PAL_COLOR0: pal_next[0] = color_t'(cfg_data);
                REG_PAL_COLOR1: pal_next[1] = color_t'(cfg_data);
                REG_PAL_COLOR2: pal_next[2] = color_t'(cfg_data);
                REG_PAL_COLOR3: pal_next[3] = color_t'(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAL_ENTRIES; i++)
            begin
                pal_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < PAL_ENTRIES; i++)
            begin
                pal_reg[i] <= pal_next[i];
            end
        end
    end

    // one independent lane per palette entry
    always_comb
    begin
        for (int i = 0; i < PAL_ENTRIES; i++)
        begin
            mid_word.lane_dist[i] = sq_dist(pixel, pal_reg[i]);
        end
        mid_word.tile_last = pixel.tile_last;
    end

endmodule

>>> design/npq_queue.sv
// npq_queue: short queue of classified words between front and back
// lets either side stall on its own
// depends on npq_pkg
module npq_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  npq_pkg::mid_word_t wr_word,
    output logic               full,
    input  logic               rd_en,
    output npq_pkg::mid_word_t rd_word,
    output logic               not_empty
);
    import npq_pkg::*;

    mid_word_t              mem_reg [MID_DEPTH];
    logic [MID_PTR_W-1:0]   wr_ptr_reg;
    logic [MID_PTR_W-1:0]   wr_ptr_next;
    logic [MID_PTR_W-1:0]   rd_ptr_reg;
    logic [MID_PTR_W-1:0]   rd_ptr_next;
    logic [MID_CNT_W-1:0]   count_reg;
    logic [MID_CNT_W-1:0]   count_next;
    logic                   do_wr;
    logic                   do_rd;

    assign full      = (count_reg == MID_CNT_W'(MID_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_word   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == MID_PTR_W'(MID_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == MID_PTR_W'(MID_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + MID_CNT_W'(do_wr) - MID_CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_word;
        end
    end

endmodule

>>> design/npq_back.sv
// npq_back: nearest-entry select, tile error accumulator, result queue
// takes mid words from npq_queue and presents result words
// depends on npq_pkg
module npq_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               mid_valid,
    input  npq_pkg::mid_word_t mid_word,
    output logic               mid_pop,
    output npq_pkg::result_t   result,
    output logic               empty,
    input  logic               pop
);
    import npq_pkg::*;

    result_t                res_mem_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg;
    logic [OUT_PTR_W-1:0]   wr_ptr_next;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg;
    logic [OUT_PTR_W-1:0]   rd_ptr_next;
    logic [OUT_CNT_W-1:0]   count_reg;
    logic [OUT_CNT_W-1:0]   count_next;
    logic [SUM_W-1:0]       err_sum_reg;
    logic [SUM_W-1:0]       err_sum_next;

    logic                   do_pop;
    logic                   take;
    logic [INDEX_W-1:0]     idx_lo;
    logic [INDEX_W-1:0]     idx_hi;
    logic [PIXERR_W-1:0]    best_lo;
    logic [PIXERR_W-1:0]    best_hi;
    logic [INDEX_W-1:0]     best_idx;
    logic [PIXERR_W-1:0]    best;
    logic [SUM_W:0]         sum_wide;
    logic [SUM_W-1:0]       sum_sat;
    result_t                res_word;

    assign empty   = (count_reg == '0);
    assign do_pop  = pop && !empty;
    assign take    = mid_valid && ((count_reg != OUT_CNT_W'(OUT_DEPTH)) || do_pop);
    assign mid_pop = take;
    assign result  = res_mem_reg[rd_ptr_reg];

    // pairwise tree, strict less-than keeps the lower index on ties
    always_comb
    begin
        if (mid_word.lane_dist[1] < mid_word.lane_dist[0])
        begin
            best_lo = mid_word.lane_dist[1];
            idx_lo  = INDEX_W'(1);
        end
        else
        begin
            best_lo = mid_word.lane_dist[0];
            idx_lo  = INDEX_W'(0);
        end
        if (mid_word.lane_dist[3] < mid_word.lane_dist[2])
        begin
            best_hi = mid_word.lane_dist[3];
            idx_hi  = INDEX_W'(3);
        end
        else
        begin
            best_hi = mid_word.lane_dist[2];
            idx_hi  = INDEX_W'(2);
        end
        if (best_hi < best_lo)
        begin
            best     = best_hi;
            best_idx = idx_hi;
        end
        else
        begin
            best     = best_lo;
            best_idx = idx_lo;
        end
    end

    // saturating accumulate
    always_comb
    begin
        sum_wide = {1'b0, err_sum_reg} + (SUM_W + 1)'(best);
        sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

        res_word.color_index = best_idx;
        res_word.pixel_error = best;
        res_word.tile_error  = sum_sat;
        res_word.tile_done   = mid_word.tile_last;

        err_sum_next = err_sum_reg;
        if (take)
        begin
            err_sum_next = mid_word.tile_last ? '0 : sum_sat;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (take)
        begin
            wr_ptr_next = (wr_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + OUT_CNT_W'(take) - OUT_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
            err_sum_reg <= '0;
        end
        else
        begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            count_reg   <= count_next;
            err_sum_reg <= err_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_mem_reg[wr_ptr_reg] <= res_word;
        end
    end

endmodule

>>> design/nearest_palette_pixel_quantizer.sv
// nearest_palette_pixel_quantizer: top level, maps rgb pixels to the
// nearest of four palette colors and sums the error over a tile
// depends on npq_pkg, npq_front, npq_queue, npq_back
//
//  channel   handshake               word
//  -------   ---------------------   ------------------------------------------
//  pixel     push / full             red, green, blue, tile_last (pixel_t)
//  result    empty / pop             color_index, pixel_error, tile_error,
//                                    tile_done (result_t)
//  config    cfg_valid / cfg_ready   cfg_index (palette entry), cfg_data (rgb)
//
// one pixel per cycle sustained while full is low; the front computes all four
// distances in the cycle the pixel is pushed, the back selects and accumulates
// one word a cycle while the result queue has room or is popped; a pushed pixel
// is written to the mid queue, then to the result queue, and can be popped once
// it is held there; reset clears the palette to black, the tile error sum and
// both queues; the four-word mid queue and two-word result queue absorb stalls
// on pop; full rises only once both are packed
module nearest_palette_pixel_quantizer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  npq_pkg::pixel_t                 pixel,
    output logic                            empty,
    input  logic                            pop,
    output npq_pkg::result_t                result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [npq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [npq_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import npq_pkg::*;

    mid_word_t front_word;
    mid_word_t queue_word;
    logic      queue_not_empty;
    logic      queue_pop;

    // classify: palette registers and distance lanes
    npq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel),
        .mid_word  (front_word)
    );

    // decoupling queue, its full flag is the input back-pressure
    npq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (push),
        .wr_word   (front_word),
        .full      (full),
        .rd_en     (queue_pop),
        .rd_word   (queue_word),
        .not_empty (queue_not_empty)
    );

    // select nearest entry, accumulate, hold finished words
    npq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_valid (queue_not_empty),
        .mid_word  (queue_word),
        .mid_pop   (queue_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule
